// ===== rtl/cdp_pkg.sv =====
// ----------------------------------------------------------------------------
// cdp_pkg
// Shared types, constants and helpers for the channel delay and polarity block.
// ----------------------------------------------------------------------------
package cdp_pkg;

	// field widths of the request and result payloads
	localparam int SAMPLE_W   = 24;
	localparam int CHAN_W     = 4;
	localparam int DELAY_IN_W = 12;

	// default sizing of the per-channel stores
	localparam int DELAY_DEPTH_DEF = 2048;
	localparam int CHANNELS_DEF    = 16;

	// request kinds
	localparam logic KIND_SAMPLE   = 1'b0;
	localparam logic KIND_SETTINGS = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [CHAN_W-1:0]          chan_t;
	typedef logic [DELAY_IN_W-1:0]      delay_in_t;

	// what the result stage needs to know about one sample request
	typedef struct packed {
		logic    valid;     // a sample request occupies the stage
		chan_t   channel;
		sample_t sample;    // sample as received
		logic    sel_mem;   // result comes from the delay store read
		logic    sel_zero;  // delayed entry never written, reads as zero
		logic    invert;    // negate the selected value
	} res_info_t;

	localparam sample_t SMP_MAX = sample_t'(24'h7F_FFFF);
	localparam sample_t SMP_MIN = sample_t'(24'h80_0000);

	// two's complement negate that saturates at full scale
	function automatic sample_t neg_sat(input sample_t s);
		sample_t r;
		if (s == SMP_MIN) begin
			r = SMP_MAX;
		end else begin
			r = -s;
		end
		return r;
	endfunction

endpackage

// ===== rtl/cdp_in_if.sv =====
// ----------------------------------------------------------------------------
// cdp_in_if
// Request channel: sample or channel-settings request with valid/ready.
// ----------------------------------------------------------------------------
interface cdp_in_if;
	import cdp_pkg::*;

	logic      valid;
	logic      ready;
	logic      kind;
	chan_t     channel;
	sample_t   sample_in;
	logic      invert_in;
	delay_in_t delay_in;

	modport source (output valid, kind, channel, sample_in, invert_in, delay_in,
		input ready);
	modport sink (input valid, kind, channel, sample_in, invert_in, delay_in,
		output ready);
endinterface

// ===== rtl/cdp_out_if.sv =====
// ----------------------------------------------------------------------------
// cdp_out_if
// Result channel: processed sample with its channel, valid/ready.
// ----------------------------------------------------------------------------
interface cdp_out_if;
	import cdp_pkg::*;

	logic    valid;
	logic    ready;
	chan_t   channel_out;
	sample_t sample_out;

	modport source (output valid, channel_out, sample_out, input ready);
	modport sink (input valid, channel_out, sample_out, output ready);
endinterface

// ===== rtl/channel_delay_polarity.sv =====
// ----------------------------------------------------------------------------
// channel_delay_polarity
// Per-channel sample delay line with polarity invert for 24-bit audio.
//
// Channels: item (sink) takes sample requests (kind 0) and channel-settings
// requests (kind 1); result (source) gives one processed sample per sample
// request, in request order, and nothing for a settings request.
// Path: a sample request accepted on item passes through the input register,
// the delay store read register and the output register to result.
// Throughput: one request per cycle while item.ready stays high, set by the
// single write and single read port of the delay store; a settings request
// takes effect for the very next request.
// Reset: settings, write positions and fill marks clear at once; the store
// itself is not swept, entries never written read as zero, so the block takes
// requests right after reset.
// Stall: when result is held off, one result waits in the output register and
// one in a skid entry; item.ready drops only once the skid entry is taken, and
// the whole pipeline then holds until result takes a result again.
// ----------------------------------------------------------------------------
module channel_delay_polarity #(
	parameter int DELAY_DEPTH = cdp_pkg::DELAY_DEPTH_DEF,
	parameter int CHANNELS    = cdp_pkg::CHANNELS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	cdp_in_if.sink    item,
	cdp_out_if.source result
);
	import cdp_pkg::*;

	localparam int AW  = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
	localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic      en;
	logic      valid_s1;
	logic      kind_s1;
	chan_t     channel_s1;
	sample_t   sample_s1;
	logic      invert_s1;
	delay_in_t delay_s1;

	logic           mem_we;
	logic           mem_re;
	logic [CHW-1:0] mem_ch;
	logic [AW-1:0]  mem_wpos;
	logic [AW-1:0]  mem_rpos;
	sample_t        rdata;
	res_info_t      info;
	res_info_t      info_s2;

	assign item.ready = en;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && item.valid) begin
			kind_s1    <= item.kind;
			channel_s1 <= item.channel;
			sample_s1  <= item.sample_in;
			invert_s1  <= item.invert_in;
			delay_s1   <= item.delay_in;
		end
	end

	cdp_ctrl #(
		.DELAY_DEPTH (DELAY_DEPTH),
		.CHANNELS    (CHANNELS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.valid_s1   (valid_s1),
		.kind_s1    (kind_s1),
		.channel_s1 (channel_s1),
		.sample_s1  (sample_s1),
		.invert_s1  (invert_s1),
		.delay_s1   (delay_s1),
		.mem_we     (mem_we),
		.mem_re     (mem_re),
		.mem_ch     (mem_ch),
		.mem_wpos   (mem_wpos),
		.mem_rpos   (mem_rpos),
		.info       (info)
	);

	cdp_mem #(
		.DELAY_DEPTH (DELAY_DEPTH),
		.CHANNELS    (CHANNELS)
	) u_mem (
		.clk   (clk),
		.en    (en),
		.we    (mem_we),
		.re    (mem_re),
		.ch    (mem_ch),
		.wpos  (mem_wpos),
		.rpos  (mem_rpos),
		.wdata (sample_s1),
		.rdata (rdata)
	);

	// stage two register, alongside the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			info_s2 <= '0;
		end else if (en) begin
			info_s2 <= info;
		end
	end

	cdp_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.info_s2 (info_s2),
		.rdata   (rdata),
		.en      (en),
		.result  (result)
	);

endmodule

// ===== rtl/cdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdp_ctrl
// Per-channel settings and write positions; forms the delay store addresses
// and the result selection for the request in stage one.
// ----------------------------------------------------------------------------
module cdp_ctrl #(
	parameter int DELAY_DEPTH = cdp_pkg::DELAY_DEPTH_DEF,
	parameter int CHANNELS    = cdp_pkg::CHANNELS_DEF,
	localparam int AW  = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1,
	localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_s1,
	input  logic                kind_s1,
	input  cdp_pkg::chan_t      channel_s1,
	input  cdp_pkg::sample_t    sample_s1,
	input  logic                invert_s1,
	input  cdp_pkg::delay_in_t  delay_s1,
	output logic                mem_we,
	output logic                mem_re,
	output logic [CHW-1:0]      mem_ch,
	output logic [AW-1:0]       mem_wpos,
	output logic [AW-1:0]       mem_rpos,
	output cdp_pkg::res_info_t  info
);
	import cdp_pkg::*;

	localparam logic [AW-1:0] POS_LAST = AW'(DELAY_DEPTH - 1);
	localparam int unsigned   DMAX     = DELAY_DEPTH - 1;

	logic [AW-1:0] wpos_q  [CHANNELS];
	logic          wrap_q  [CHANNELS];
	logic          inv_q   [CHANNELS];
	logic [AW-1:0] dly_q   [CHANNELS];

	logic          ch_ok;
	logic [CHW-1:0] idx;
	logic          inv;
	logic [AW-1:0] dly;
	logic [AW-1:0] wp;
	logic          wrapped;
	logic          is_smp;
	logic          is_set;
	logic          active;
	logic          use_dly;
	logic [AW-1:0] rp;
	logic [AW-1:0] gap;
	logic          written;
	logic [AW-1:0] dly_new;

	// look up the channel's state
	assign ch_ok   = (32'(channel_s1) < 32'(CHANNELS));
	assign idx     = CHW'(channel_s1);
	assign inv     = inv_q[idx];
	assign dly     = dly_q[idx];
	assign wp      = wpos_q[idx];
	assign wrapped = wrap_q[idx];

	assign is_smp  = valid_s1 && (kind_s1 == KIND_SAMPLE);
	assign is_set  = valid_s1 && (kind_s1 == KIND_SETTINGS) && ch_ok;
	assign active  = is_smp && ch_ok && (inv || (dly != '0));
	assign use_dly = active && (dly != '0);

	// read position, delay places behind the write position with wrap
	assign gap = dly - wp;
	always_comb begin
		if (wp >= dly) begin
			rp = wp - dly;
		end else begin
			rp = AW'((AW+1)'(DELAY_DEPTH) - {1'b0, gap});
		end
	end

	// the store fills in order from zero, so an entry is written once the
	// channel has wrapped or the entry lies below the write position
	assign written = wrapped || (rp < wp);

	// clamp of a new delay setting
	always_comb begin
		if (32'(delay_s1) > DMAX) begin
			dly_new = POS_LAST;
		end else begin
			dly_new = AW'(delay_s1);
		end
	end

	assign mem_we   = active;
	assign mem_re   = use_dly;
	assign mem_ch   = idx;
	assign mem_wpos = wp;
	assign mem_rpos = rp;

	always_comb begin
		info.valid    = is_smp;
		info.channel  = channel_s1;
		info.sample   = sample_s1;
		info.sel_mem  = use_dly && written;
		info.sel_zero = use_dly && !written;
		info.invert   = active && inv;
	end

	// per-channel state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				wpos_q[i] <= '0;
				wrap_q[i] <= 1'b0;
				inv_q[i]  <= 1'b0;
				dly_q[i]  <= '0;
			end
		end else if (en) begin
			if (is_set) begin
				inv_q[idx] <= invert_s1;
				dly_q[idx] <= dly_new;
			end
			if (active) begin
				if (wp == POS_LAST) begin
					wpos_q[idx] <= '0;
					wrap_q[idx] <= 1'b1;
				end else begin
					wpos_q[idx] <= wp + AW'(1);
				end
			end
		end
	end

endmodule

// ===== rtl/cdp_mem.sv =====
// ----------------------------------------------------------------------------
// cdp_mem
// Delay store: one write and one registered read per cycle while en is high.
// ----------------------------------------------------------------------------
module cdp_mem #(
	parameter int DELAY_DEPTH = cdp_pkg::DELAY_DEPTH_DEF,
	parameter int CHANNELS    = cdp_pkg::CHANNELS_DEF,
	localparam int AW  = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1,
	localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic             re,
	input  logic [CHW-1:0]   ch,
	input  logic [AW-1:0]    wpos,
	input  logic [AW-1:0]    rpos,
	input  cdp_pkg::sample_t wdata,
	output cdp_pkg::sample_t rdata
);
	import cdp_pkg::*;

	sample_t mem [CHANNELS][DELAY_DEPTH];
	sample_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (en && we) begin
			mem[ch][wpos] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (en && re) begin
			rdata_q <= mem[ch][rpos];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/cdp_out.sv =====
// ----------------------------------------------------------------------------
// cdp_out
// Result selection and polarity, then output register with a skid entry.
// ----------------------------------------------------------------------------
module cdp_out (
	input  logic               clk,
	input  logic               arst_n,
	input  cdp_pkg::res_info_t info_s2,
	input  cdp_pkg::sample_t   rdata,
	output logic               en,
	cdp_out_if.source          result
);
	import cdp_pkg::*;

	sample_t sel;
	sample_t res;
	logic    push;

	logic    out_valid_q;
	chan_t   out_chan_q;
	sample_t out_smp_q;
	logic    skid_valid_q;
	chan_t   skid_chan_q;
	sample_t skid_smp_q;

	// pick the passed, delayed or zero value, then apply polarity
	always_comb begin
		if (info_s2.sel_mem) begin
			sel = rdata;
		end else if (info_s2.sel_zero) begin
			sel = '0;
		end else begin
			sel = info_s2.sample;
		end
		res = info_s2.invert ? neg_sat(sel) : sel;
	end

	// the pipeline moves while the skid entry is free
	assign en   = !skid_valid_q;
	assign push = en && info_s2.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || result.ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (!out_valid_q || result.ready) begin
			if (skid_valid_q) begin
				out_chan_q <= skid_chan_q;
				out_smp_q  <= skid_smp_q;
			end else if (push) begin
				out_chan_q <= info_s2.channel;
				out_smp_q  <= res;
			end
		end else if (push) begin
			skid_chan_q <= info_s2.channel;
			skid_smp_q  <= res;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.channel_out = out_chan_q;
	assign result.sample_out  = out_smp_q;

endmodule

// ===== bench/delay_polarity_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delay_polarity_checker
// Watches both channels of the delay and polarity block, keeps its own copy
// of every channel's delay line and settings, predicts the result of each
// accepted sample request and compares it field by field in request order.
// ----------------------------------------------------------------------------
module delay_polarity_checker (
	input  logic        clk,
	input  logic        arst_n,
	cdp_in_if           item,
	cdp_out_if          result,
	output int unsigned mismatches,
	output int unsigned outstanding,
	output int unsigned compared
);
	import cdp_pkg::*;

	localparam int DEPTH = DELAY_DEPTH_DEF;
	localparam int NCHAN = CHANNELS_DEF;
	localparam int POS_W = $clog2(DEPTH);

	typedef logic [POS_W-1:0] pos_t;

	typedef struct packed {
		chan_t   channel;
		sample_t sample;
	} delayed_sample_t;

	// per-channel delay lines and settings, all zero after reset
	sample_t line_mem [NCHAN][DEPTH];
	pos_t    wr_pos [NCHAN];
	pos_t    ch_delay [NCHAN];
	logic    ch_invert [NCHAN];

	delayed_sample_t due_samples [$];
	int unsigned     n_bad;
	int unsigned     n_waiting;
	int unsigned     n_compared;

	assign mismatches  = n_bad;
	assign outstanding = n_waiting;
	assign compared    = n_compared;

	// one line per mismatch, and count it
	task automatic report_mismatch(input string msg);
		n_bad++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// negate, full-scale negative clips to full-scale positive
	function automatic sample_t negate_clipped(input sample_t s);
		sample_t r;
		if (s == SMP_MIN) begin
			r = SMP_MAX;
		end else begin
			r = -s;
		end
		return r;
	endfunction

	// update settings or run one sample through its channel's delay line
	task automatic delay_and_invert(input logic kind, input chan_t ch, input sample_t smp,
		input logic inv, input delay_in_t dly);
		pos_t            wp;
		pos_t            rp;
		sample_t         val;
		delayed_sample_t due;
		if (kind == KIND_SETTINGS) begin
			if (ch < NCHAN) begin
				ch_invert[ch] = inv;
				ch_delay[ch]  = (dly > DEPTH - 1) ? pos_t'(DEPTH - 1) : pos_t'(dly);
			end
		end else begin
			val = smp;
			if (ch < NCHAN && (ch_invert[ch] || ch_delay[ch] != '0)) begin
				wp = wr_pos[ch];
				line_mem[ch][wp] = smp;
				if (ch_delay[ch] != '0) begin
					rp  = pos_t'((int'(wp) + DEPTH - int'(ch_delay[ch])) % DEPTH);
					val = line_mem[ch][rp];
				end
				wr_pos[ch] = pos_t'((int'(wp) + 1) % DEPTH);
				if (ch_invert[ch]) begin
					val = negate_clipped(val);
				end
			end
			due.channel = ch;
			due.sample  = val;
			due_samples.insert(due_samples.size(), due);
		end
	endtask

	// results are checked before new requests so an early result is caught
	always @(posedge clk) begin
		delayed_sample_t want;
		if (!arst_n) begin
			for (int c = 0; c < NCHAN; c++) begin
				wr_pos[c]    = '0;
				ch_delay[c]  = '0;
				ch_invert[c] = 1'b0;
				for (int e = 0; e < DEPTH; e++) begin
					line_mem[c][e] = '0;
				end
			end
			due_samples.delete();
		end else begin
			if (result.valid && result.ready) begin
				if (due_samples.size() == 0) begin
					report_mismatch($sformatf("result ch %0d sample %0d with no request waiting",
						result.channel_out, result.sample_out));
				end else begin
					want = due_samples.pop_front();
					n_compared++;
					if (result.channel_out !== want.channel) begin
						report_mismatch($sformatf("channel_out %0d, expected %0d",
							result.channel_out, want.channel));
					end
					if (result.sample_out !== want.sample) begin
						report_mismatch($sformatf("sample_out %0d on ch %0d, expected %0d",
							result.sample_out, want.channel, want.sample));
					end
				end
			end
			if (item.valid && item.ready) begin
				delay_and_invert(item.kind, item.channel, item.sample_in, item.invert_in,
					item.delay_in);
			end
		end
		n_waiting = due_samples.size();
	end

endmodule

// ===== bench/channel_delay_polarity_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// channel_delay_polarity_tb
// Drives sample and settings requests into the delay and polarity block with
// random gaps and result stalls: a directed opening, random mixed traffic on
// a few busy channels, and a short fill of one channel read far back across
// the wrap point of its line.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module channel_delay_polarity_tb;
	import cdp_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 500;
	localparam int PHASES       = 5;
	localparam int FILL_SAMPLES = 24;
	localparam int DRAIN_CYCLES = 8;

	logic        clk;
	logic        arst_n;
	int unsigned send_idle_pct;
	int unsigned drain_stall_pct;
	int unsigned stall_left;
	int unsigned quiet_cycles;
	int unsigned n_samples;
	int unsigned n_settings;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned compared;

	cdp_in_if  item_ch ();
	cdp_out_if result_ch ();

	channel_delay_polarity i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	delay_polarity_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.compared    (compared)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idle length: mostly none or short, now and then long
	function automatic int unsigned idle_len(input int unsigned pct);
		int unsigned n;
		n = 0;
		if ($urandom_range(99) < pct) begin
			n = ($urandom_range(9) < 8) ? $urandom_range(3, 1) : $urandom_range(40, 10);
		end
		return n;
	endfunction

	// result side stalls
	always @(posedge clk) begin
		int unsigned n;
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_ch.ready <= 1'b0;
		end else begin
			n = idle_len(drain_stall_pct);
			if (n != 0) begin
				stall_left <= n - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no request moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) ||
			(result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
			$display("watchdog: nothing accepted for %0d cycles, %0d results outstanding",
				IDLE_LIMIT, outstanding);
			$display("channel_delay_polarity test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// present one request, optionally after a gap, and hold it until taken
	task automatic send_request(input logic kind, input chan_t ch, input sample_t smp,
		input logic inv, input delay_in_t dly);
		int unsigned gap;
		gap = idle_len(send_idle_pct);
		if (gap != 0) begin
			item_ch.valid     <= 1'b0;
			item_ch.kind      <= logic'($urandom_range(1));
			item_ch.channel   <= chan_t'($urandom);
			item_ch.sample_in <= sample_t'($urandom);
			item_ch.invert_in <= logic'($urandom_range(1));
			item_ch.delay_in  <= delay_in_t'($urandom);
			repeat (gap) @(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.kind      <= kind;
		item_ch.channel   <= ch;
		item_ch.sample_in <= smp;
		item_ch.invert_in <= inv;
		item_ch.delay_in  <= dly;
		do @(posedge clk); while (!item_ch.ready);
		if (kind == KIND_SETTINGS) begin
			n_settings++;
		end else begin
			n_samples++;
		end
	endtask

	// unused fields carry random values
	task automatic send_sample(input chan_t ch, input sample_t smp);
		send_request(KIND_SAMPLE, ch, smp, logic'($urandom_range(1)), delay_in_t'($urandom));
	endtask

	task automatic send_settings(input chan_t ch, input logic inv, input delay_in_t dly);
		send_request(KIND_SETTINGS, ch, sample_t'($urandom), inv, dly);
	endtask

	// random request, mostly on four busy channels with short delays
	task automatic send_random();
		chan_t     ch;
		sample_t   smp;
		delay_in_t dly;
		ch = ($urandom_range(9) < 7) ? chan_t'($urandom_range(3)) : chan_t'($urandom);
		case ($urandom_range(9))
			0: smp = SMP_MIN;
			1: smp = SMP_MAX;
			2: smp = sample_t'($urandom_range(1)) - sample_t'(1);
			default: smp = sample_t'($urandom);
		endcase
		case ($urandom_range(19))
			0, 1, 2: dly = delay_in_t'($urandom);
			3, 4, 5, 6, 7: dly = delay_in_t'($urandom_range(40));
			default: dly = delay_in_t'($urandom_range(6));
		endcase
		if ($urandom_range(99) < 12) begin
			send_settings(ch, logic'($urandom_range(1)), dly);
		end else begin
			send_sample(ch, smp);
		end
	endtask

	// drop valid and let every expected result come back
	task automatic drain_results();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
	endtask

	initial begin
		arst_n            <= 1'b0;
		item_ch.valid     <= 1'b0;
		item_ch.kind      <= KIND_SAMPLE;
		item_ch.channel   <= '0;
		item_ch.sample_in <= '0;
		item_ch.invert_in <= 1'b0;
		item_ch.delay_in  <= '0;
		n_samples         = 0;
		n_settings        = 0;
		send_idle_pct     = 0;
		drain_stall_pct   = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// pass-through on a channel never set
		send_sample(chan_t'(0), SMP_MAX);
		send_sample(chan_t'(0), SMP_MIN);
		// invert only, full-scale negative saturates
		send_settings(chan_t'(1), 1'b1, delay_in_t'(0));
		send_sample(chan_t'(1), SMP_MIN);
		send_sample(chan_t'(1), SMP_MAX);
		send_sample(chan_t'(1), sample_t'(0));
		send_sample(chan_t'(1), sample_t'(-1));
		// delay of one, first read hits an unwritten entry
		send_settings(chan_t'(3), 1'b0, delay_in_t'(1));
		send_sample(chan_t'(3), sample_t'(24'h12_3456));
		send_sample(chan_t'(3), sample_t'(24'hAB_CDEF));
		send_sample(chan_t'(3), SMP_MIN);
		// delays above range clamp to depth minus one
		send_settings(chan_t'(2), 1'b0, delay_in_t'(12'hFFF));
		send_sample(chan_t'(2), sample_t'(24'h55_AA55));
		send_settings(chan_t'(15), 1'b1, delay_in_t'(DELAY_DEPTH_DEF));
		send_sample(chan_t'(15), SMP_MAX);
		// delayed full-scale negative, then inverted
		send_settings(chan_t'(4), 1'b1, delay_in_t'(2));
		send_sample(chan_t'(4), SMP_MIN);
		send_sample(chan_t'(4), sample_t'(1));
		send_sample(chan_t'(4), sample_t'(2));
		send_sample(chan_t'(4), sample_t'(3));
		// back to pass-through, write position must hold
		send_settings(chan_t'(3), 1'b0, delay_in_t'(0));
		send_sample(chan_t'(3), sample_t'(24'h00_0777));
		send_settings(chan_t'(3), 1'b0, delay_in_t'(1));
		send_sample(chan_t'(3), sample_t'(24'h7F_0000));

		// random traffic, idling and stalls vary by phase
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin send_idle_pct = 30; drain_stall_pct = 30; end
				1: begin send_idle_pct = 10; drain_stall_pct = 60; end
				2: begin send_idle_pct = 0;  drain_stall_pct = 0;  end
				3: begin send_idle_pct = 60; drain_stall_pct = 10; end
				default: begin send_idle_pct = 25; drain_stall_pct = 25; end
			endcase
			for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
				send_random();
			end
			if (ph == 1) begin
				drain_results();
			end
		end

		// fill part of one channel's line, then read far back across its wrap point
		send_idle_pct   = 0;
		drain_stall_pct = 5;
		send_settings(chan_t'(5), 1'b0, delay_in_t'(7));
		repeat (FILL_SAMPLES) send_sample(chan_t'(5), sample_t'($urandom));
		send_settings(chan_t'(5), 1'b1, delay_in_t'(DELAY_DEPTH_DEF - 1));
		repeat (4) send_sample(chan_t'(5), sample_t'($urandom));
		send_settings(chan_t'(5), 1'b1, delay_in_t'(20));
		repeat (4) send_sample(chan_t'(5), sample_t'($urandom));

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d sample and %0d settings requests, %0d results compared",
			n_samples, n_settings, compared);
		$display("covered saturating negation, clamped delays, unwritten reads, wrapped reads");
		if (mismatches == 0) begin
			$display("channel_delay_polarity test passed");
		end else begin
			$display("channel_delay_polarity test failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/cdp_pkg.sv
rtl/cdp_in_if.sv
rtl/cdp_out_if.sv
rtl/cdp_ctrl.sv
rtl/cdp_mem.sv
rtl/cdp_out.sv
rtl/channel_delay_polarity.sv
bench/delay_polarity_checker.sv
bench/channel_delay_polarity_tb.sv
